/* rtl/u8u16_pkg.sv */
package u8u16_pkg;

	localparam int unsigned WinBytes = 4;

	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;

	// Sequence lengths implied by a lead byte.
	localparam logic [2:0] LEN_BAD   = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	// Result of one pass of the decode unit over the window.
	typedef struct packed {
		logic        emit;
		logic        pair;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic [2:0]  drop;
	} step_t;

	// Unit handed to the output register.
	typedef struct packed {
		logic [15:0] unit;
		logic        run_last;
		logic        text_end;
	} push_t;

endpackage

/* rtl/u8u16_decode.sv */
module u8u16_decode
	import u8u16_pkg::*;
(
	input  logic [31:0] win,
	input  logic [2:0]  count,
	input  logic        fin,
	output step_t       step
);

	logic [7:0]  lead;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [7:0]  b3;
	logic [2:0]  need;
	logic        cont_ok;
	logic [20:0] cp;
	logic [20:0] v;

	assign lead = win[7:0];
	assign b1   = win[15:8];
	assign b2   = win[23:16];
	assign b3   = win[31:24];

	always_comb begin
		if (lead[7] == 1'b0) begin
			need = LEN_ONE;
		end else if (lead[7:5] == 3'b110) begin
			need = LEN_TWO;
		end else if (lead[7:4] == 4'b1110) begin
			need = LEN_THREE;
		end else if (lead[7:3] == 5'b11110) begin
			need = LEN_FOUR;
		end else begin
			need = LEN_BAD;
		end
	end

	assign cont_ok = (need < LEN_TWO   || b1[7:6] == 2'b10) &&
	                 (need < LEN_THREE || b2[7:6] == 2'b10) &&
	                 (need < LEN_FOUR  || b3[7:6] == 2'b10);

	always_comb begin
		case (need)
			LEN_TWO:   cp = {10'd0, lead[4:0], b1[5:0]};
			LEN_THREE: cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
			LEN_FOUR:  cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default:   cp = {13'd0, lead};
		endcase
	end

	// The one subtractor of the block: offset of a supplementary value.
	assign v = cp - SUPP_BASE;

	always_comb begin
		step.emit  = 1'b1;
		step.pair  = 1'b0;
		step.unit0 = REPLACEMENT;
		step.unit1 = {6'd0, v[9:0]} | LO_SURR;
		step.drop  = 3'd1;
		if (count == 3'd0) begin
			step.emit = 1'b0;
		end else if (need == LEN_BAD) begin
			step.drop = 3'd1;
		end else if (count < need) begin
			// A cut-off sequence waits, unless the text ends here.
			step.emit = fin;
			step.drop = count;
		end else if (!cont_ok) begin
			step.drop = 3'd1;
		end else begin
			step.drop = need;
			if (cp > MAX_SCALAR) begin
				step.unit0 = REPLACEMENT;
			end else if (cp >= SUPP_BASE) begin
				step.pair  = 1'b1;
				step.unit0 = {6'd0, v[19:10]} | HI_SURR;
			end else begin
				step.unit0 = cp[15:0];
			end
		end
	end

endmodule

/* rtl/u8u16_outreg.sv */
module u8u16_outreg
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  push_t       data,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [15:0] code_unit,
	output logic        run_last,
	output logic        text_end
);

	logic  valid_q;
	push_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign out_valid = valid_q;
	assign code_unit = data_q.unit;
	assign run_last  = data_q.run_last;
	assign text_end  = data_q.text_end;

endmodule

/* rtl/utf8_to_utf16_transcoder.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  in_byte[7:0], final_byte
// output    out        out_valid/out_stall  code_unit[15:0], run_last, text_end
//
// Each accepted byte joins a four-byte window that a shared decode unit scans once
// per cycle, producing one code unit (the low half of a surrogate pair is produced
// on its own, from S_LOW) or finding nothing more to do. A new byte is taken only
// when it finds nothing more to do, so no byte is taken while units are still being
// produced for the bytes before it. All work waits while the output register is
// full and stalled. Reset empties the window and the output register.
module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        run_last,
	output logic        text_end
);

	typedef enum logic {
		S_RUN,
		S_LOW
	} state_t;

	state_t      state_q;
	logic [31:0] win_q;
	logic [2:0]  count_q;
	logic        fin_q;
	logic        hold_v_q;
	logic [15:0] hold_q;
	logic [15:0] low_q;

	step_t       step;
	push_t       push_data;
	logic        out_free;
	logic        produce;
	logic        flush;
	logic        accept;
	logic        push;
	logic [31:0] win_shift;
	logic [31:0] win_fill;

	u8u16_decode u_decode (
		.win   (win_q),
		.count (count_q),
		.fin   (fin_q),
		.step  (step)
	);

	// Nothing moves while the output register holds a unit that is stalled.
	assign out_free = !out_valid || !out_stall;

	// A unit is produced into the hold register; the one held before it is
	// pushed out then. At the end of a byte's work the held unit goes out as
	// the last unit of that byte, so run_last and text_end are known in time.
	assign produce = out_free && ((state_q == S_LOW) || (state_q == S_RUN && step.emit));
	assign flush   = out_free && (state_q == S_RUN) && !step.emit && hold_v_q;
	assign push    = (produce && hold_v_q) || flush;

	assign in_stall = !(out_free && (state_q == S_RUN) && !step.emit);
	assign accept   = in_valid && !in_stall;

	assign push_data.unit     = hold_q;
	assign push_data.run_last = flush;
	assign push_data.text_end = flush && fin_q;

	// Remove the bytes the decode unit has consumed.
	always_comb begin
		case (step.drop)
			3'd1:    win_shift = {8'h00, win_q[31:8]};
			3'd2:    win_shift = {16'h0000, win_q[31:16]};
			3'd3:    win_shift = {24'h000000, win_q[31:24]};
			default: win_shift = 32'h0000_0000;
		endcase
	end

	// Write the new byte into the first free lane.
	always_comb begin
		win_fill = win_q;
		for (int i = 0; i < WinBytes; i++) begin
			if (count_q[1:0] == i[1:0]) begin
				win_fill[i*8 +: 8] = in_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RUN;
			count_q  <= '0;
			fin_q    <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_RUN: begin
					if (produce) begin
						count_q  <= count_q - step.drop;
						hold_v_q <= 1'b1;
						if (step.pair) begin
							state_q <= S_LOW;
						end
					end else if (out_free) begin
						hold_v_q <= 1'b0;
						if (accept) begin
							count_q <= count_q + 3'd1;
							fin_q   <= final_byte;
						end
					end
				end
				S_LOW: begin
					if (produce) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RUN && produce) begin
			win_q  <= win_shift;
			hold_q <= step.unit0;
			low_q  <= step.unit1;
		end else if (state_q == S_LOW && produce) begin
			hold_q <= low_q;
		end else if (accept) begin
			win_q <= win_fill;
		end
	end

	u8u16_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (push),
		.data      (push_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.code_unit (code_unit),
		.run_last  (run_last),
		.text_end  (text_end)
	);

endmodule
